[rtl/sexpr_token_lexer_assert.svh]
// Assertion helpers for the lexer top level; clock and reset names are fixed.
`ifndef SEXPR_TOKEN_LEXER_ASSERT_SVH
`define SEXPR_TOKEN_LEXER_ASSERT_SVH

// Same-cycle implication.
`define SXL_ASSERT_NOW(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lexer check failed");

// Implication checked in the next cycle.
`define SXL_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lexer check failed");

`endif

[rtl/sxl_pkg.sv]
`default_nettype none

package sxl_pkg;

    localparam int POSITION_BITS = 16;
    localparam int OFFSET_BITS   = 32;
    localparam int LENGTH_BITS   = 16;

    typedef logic [POSITION_BITS-1:0] pos_t;
    typedef logic [OFFSET_BITS-1:0]   off_t;
    typedef logic [LENGTH_BITS-1:0]   len_t;

    localparam pos_t POS_MAX = '1;
    localparam len_t LEN_MAX = '1;

    typedef enum logic [3:0] {
        K_LPAREN = 4'd0,
        K_RPAREN = 4'd1,
        K_LBRACK = 4'd2,
        K_RBRACK = 4'd3,
        K_QUOTE  = 4'd4,
        K_STRING = 4'd5,
        K_NUMBER = 4'd6,
        K_ATOM   = 4'd7,
        K_BADCHR = 4'd8,
        K_UNTERM = 4'd9,
        K_EOF    = 4'd10
    } tok_kind_t;

    typedef enum logic [6:0] {
        M_IDLE    = 7'b0000001,
        M_COMMENT = 7'b0000010,
        M_STRING  = 7'b0000100,
        M_ESCAPE  = 7'b0001000,
        M_MINUS   = 7'b0010000,
        M_NUMBER  = 7'b0100000,
        M_ATOM    = 7'b1000000
    } lex_mode_t;

    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_CR      = 8'h0D;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_DQUOTE  = 8'h22;
    localparam logic [7:0] CH_QUOTE   = 8'h27;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_DOT     = 8'h2E;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_COLON   = 8'h3A;
    localparam logic [7:0] CH_SEMI    = 8'h3B;
    localparam logic [7:0] CH_LT      = 8'h3C;
    localparam logic [7:0] CH_EQ      = 8'h3D;
    localparam logic [7:0] CH_GT      = 8'h3E;
    localparam logic [7:0] CH_QMARK   = 8'h3F;
    localparam logic [7:0] CH_LBRACK  = 8'h5B;
    localparam logic [7:0] CH_BSLASH  = 8'h5C;
    localparam logic [7:0] CH_RBRACK  = 8'h5D;
    localparam logic [7:0] CH_UNDER   = 8'h5F;

    typedef struct packed {
        tok_kind_t  kind;
        pos_t       line;
        pos_t       column;
        off_t       offset;
        len_t       length;
        logic [7:0] bad;
        logic       last;
    } tok_rec_t;

    // Up to two token records produced by one accepted word.
    typedef struct packed {
        logic [1:0] cnt;
        tok_rec_t   rec0;
        tok_rec_t   rec1;
    } tok_pair_t;

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_atom_byte(input logic [7:0] b);
        return (b inside {[8'h30:8'h39], [8'h61:8'h7A], [8'h41:8'h5A]}) ||
               (b inside {CH_UNDER, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH,
                          CH_EQ, CH_LT, CH_GT, CH_COLON, CH_QMARK});
    endfunction

endpackage

`default_nettype wire

[rtl/sxl_core.sv]
`default_nettype none

module sxl_core import sxl_pkg::*; (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       step,
    input  wire logic [7:0] in_byte,
    input  wire logic       is_end,
    output tok_pair_t       pair
);

    lex_mode_t mode_reg, mode_next;
    pos_t      line_reg, line_next;
    pos_t      col_reg, col_next;
    off_t      off_reg, off_next;
    pos_t      tok_line_reg, tok_line_next;
    pos_t      tok_col_reg, tok_col_next;
    off_t      tok_off_reg, tok_off_next;
    len_t      tok_len_reg, tok_len_next;

    always_comb begin
        logic      flush_v;
        tok_kind_t flush_kind;
        logic      second_v;
        tok_rec_t  second_rec;
        tok_rec_t  flush_rec;
        logic      do_begin;
        logic      adv_col;
        logic      grow;
        logic      line_inc;
        logic      col_reset;
        logic      capture;

        flush_v    = 1'b0;
        flush_kind = K_ATOM;
        second_v   = 1'b0;
        second_rec = '0;
        do_begin   = 1'b0;
        adv_col    = 1'b0;
        grow       = 1'b0;
        line_inc   = 1'b0;
        col_reset  = 1'b0;
        capture    = 1'b0;

        mode_next     = mode_reg;
        tok_line_next = tok_line_reg;
        tok_col_next  = tok_col_reg;
        tok_off_next  = tok_off_reg;
        tok_len_next  = tok_len_reg;

        second_rec.line   = line_reg;
        second_rec.column = col_reg;
        second_rec.offset = off_reg;

        if (is_end) begin
            case (mode_reg)
                M_STRING, M_ESCAPE: begin
                    flush_v    = 1'b1;
                    flush_kind = K_UNTERM;
                end
                M_MINUS, M_ATOM: begin
                    flush_v    = 1'b1;
                    flush_kind = K_ATOM;
                end
                M_NUMBER: begin
                    flush_v    = 1'b1;
                    flush_kind = K_NUMBER;
                end
                default: ;
            endcase
            mode_next         = M_IDLE;
            second_v          = 1'b1;
            second_rec.kind   = K_EOF;
            second_rec.length = '0;
        end else begin
            case (mode_reg)
                M_COMMENT: begin
                    do_begin = (in_byte == CH_NL);
                end
                M_STRING: begin
                    adv_col = 1'b1;
                    if (in_byte == CH_DQUOTE) begin
                        flush_v    = 1'b1;
                        flush_kind = K_STRING;
                        mode_next  = M_IDLE;
                    end else begin
                        grow = 1'b1;
                        if (in_byte == CH_BSLASH) mode_next = M_ESCAPE;
                    end
                end
                M_ESCAPE: begin
                    adv_col   = 1'b1;
                    grow      = 1'b1;
                    mode_next = M_STRING;
                end
                M_MINUS: begin
                    if (is_atom_byte(in_byte)) begin
                        mode_next = is_digit(in_byte) ? M_NUMBER : M_ATOM;
                        grow      = 1'b1;
                        adv_col   = 1'b1;
                    end else begin
                        flush_v    = 1'b1;
                        flush_kind = K_ATOM;
                        do_begin   = 1'b1;
                    end
                end
                M_NUMBER: begin
                    if (is_digit(in_byte) || in_byte == CH_DOT) begin
                        grow    = 1'b1;
                        adv_col = 1'b1;
                    end else begin
                        flush_v    = 1'b1;
                        flush_kind = K_NUMBER;
                        do_begin   = 1'b1;
                    end
                end
                M_ATOM: begin
                    if (is_atom_byte(in_byte)) begin
                        grow    = 1'b1;
                        adv_col = 1'b1;
                    end else begin
                        flush_v    = 1'b1;
                        flush_kind = K_ATOM;
                        do_begin   = 1'b1;
                    end
                end
                default: begin
                    do_begin = 1'b1;
                end
            endcase

            // byte seen between tokens
            if (do_begin) begin
                mode_next         = M_IDLE;
                second_rec.length = len_t'(1);
                case (in_byte) inside
                    CH_SPACE, CH_TAB, CH_CR: begin
                        adv_col = 1'b1;
                    end
                    CH_NL: begin
                        line_inc  = 1'b1;
                        col_reset = 1'b1;
                    end
                    CH_SEMI: begin
                        mode_next = M_COMMENT;
                    end
                    CH_LPAREN, CH_RPAREN, CH_LBRACK, CH_RBRACK, CH_QUOTE: begin
                        capture  = 1'b1;
                        adv_col  = 1'b1;
                        second_v = 1'b1;
                        case (in_byte)
                            CH_LPAREN: second_rec.kind = K_LPAREN;
                            CH_RPAREN: second_rec.kind = K_RPAREN;
                            CH_LBRACK: second_rec.kind = K_LBRACK;
                            CH_RBRACK: second_rec.kind = K_RBRACK;
                            default:   second_rec.kind = K_QUOTE;
                        endcase
                    end
                    CH_DQUOTE: begin
                        capture   = 1'b1;
                        adv_col   = 1'b1;
                        mode_next = M_STRING;
                    end
                    default: begin
                        capture = 1'b1;
                        adv_col = 1'b1;
                        if (is_digit(in_byte)) begin
                            mode_next = M_NUMBER;
                        end else if (in_byte == CH_MINUS) begin
                            mode_next = M_MINUS;
                        end else if (is_atom_byte(in_byte)) begin
                            mode_next = M_ATOM;
                        end else begin
                            second_v        = 1'b1;
                            second_rec.kind = K_BADCHR;
                            second_rec.bad  = in_byte;
                        end
                    end
                endcase
            end
        end

        if (capture) begin
            tok_line_next = line_reg;
            tok_col_next  = col_reg;
            if (in_byte == CH_DQUOTE) begin
                tok_off_next = off_reg + off_t'(1);
                tok_len_next = '0;
            end else begin
                tok_off_next = off_reg;
                tok_len_next = len_t'(1);
            end
        end else if (grow && tok_len_reg != LEN_MAX) begin
            tok_len_next = tok_len_reg + len_t'(1);
        end

        off_next  = is_end ? off_reg : off_reg + off_t'(1);
        line_next = (line_inc && line_reg != POS_MAX) ? line_reg + pos_t'(1) : line_reg;
        if (col_reset) begin
            col_next = pos_t'(1);
        end else if (adv_col && col_reg != POS_MAX) begin
            col_next = col_reg + pos_t'(1);
        end else begin
            col_next = col_reg;
        end

        flush_rec        = '0;
        flush_rec.kind   = flush_kind;
        flush_rec.line   = tok_line_reg;
        flush_rec.column = tok_col_reg;
        flush_rec.offset = tok_off_reg;
        flush_rec.length = tok_len_reg;

        second_rec.last = 1'b1;
        flush_rec.last  = !second_v;

        pair.cnt  = {1'b0, flush_v} + {1'b0, second_v};
        pair.rec0 = flush_v ? flush_rec : second_rec;
        pair.rec1 = second_rec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= M_IDLE;
            line_reg     <= pos_t'(1);
            col_reg      <= pos_t'(1);
            off_reg      <= '0;
            tok_line_reg <= pos_t'(1);
            tok_col_reg  <= pos_t'(1);
            tok_off_reg  <= '0;
            tok_len_reg  <= '0;
        end else if (step) begin
            mode_reg     <= mode_next;
            line_reg     <= line_next;
            col_reg      <= col_next;
            off_reg      <= off_next;
            tok_line_reg <= tok_line_next;
            tok_col_reg  <= tok_col_next;
            tok_off_reg  <= tok_off_next;
            tok_len_reg  <= tok_len_next;
        end
    end

endmodule

`default_nettype wire

[rtl/sxl_outq.sv]
`default_nettype none

module sxl_outq import sxl_pkg::*; (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      push,
    input  wire tok_pair_t pair,
    output logic           room,
    output logic           m_valid,
    input  wire logic      m_ready,
    output tok_rec_t       head
);

    // Three-entry shift queue; entry 0 drives the output port.
    tok_rec_t   q_reg [3];
    tok_rec_t   q_next [3];
    tok_rec_t   shifted [3];
    logic [1:0] count_reg, count_next;
    logic       pop;
    logic [1:0] base;
    logic [1:0] npush;

    assign pop     = (count_reg != 2'd0) && m_ready;
    assign base    = count_reg - {1'b0, pop};
    assign npush   = push ? pair.cnt : 2'd0;
    assign room    = (count_reg <= 2'd1);
    assign m_valid = (count_reg != 2'd0);
    assign head    = q_reg[0];

    always_comb begin
        shifted[0] = pop ? q_reg[1] : q_reg[0];
        shifted[1] = pop ? q_reg[2] : q_reg[1];
        shifted[2] = q_reg[2];
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < base) begin
                q_next[i] = shifted[i];
            end else if (2'(i) == base && npush != 2'd0) begin
                q_next[i] = pair.rec0;
            end else if (3'(i) == ({1'b0, base} + 3'd1) && npush == 2'd2) begin
                q_next[i] = pair.rec1;
            end else begin
                q_next[i] = q_reg[i];
            end
        end
        count_next = base + npush;
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

[rtl/sexpr_token_lexer.sv]
// S-expression lexer: takes one text byte per word (or an end word) and sends
// token records. Each accepted word updates the registered lexer state, and its
// records go into a three-entry output queue whose head drives the m_ side, one
// record per cycle while m_ready is high. A byte is accepted every cycle as long
// as at most one record waits in that queue; a byte that both ends a number or
// atom and forms a token of its own, or an end word that closes a pending token,
// yields two records. The sustained rate is one word per cycle while m_ready is
// high and words yield at most one record, set by the output port's rate.
`default_nettype none

`include "sexpr_token_lexer_assert.svh"

module sexpr_token_lexer import sxl_pkg::*; (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_valid,
    output logic                          s_ready,
    input  wire logic [7:0]               s_in_byte,
    input  wire logic                     s_is_end,
    output logic                          m_valid,
    input  wire logic                     m_ready,
    output logic [3:0]                    m_token_kind,
    output logic [POSITION_BITS-1:0]      m_start_line,
    output logic [POSITION_BITS-1:0]      m_start_column,
    output logic [OFFSET_BITS-1:0]        m_text_offset,
    output logic [LENGTH_BITS-1:0]        m_text_length,
    output logic [7:0]                    m_bad_byte,
    output logic                          m_last_of_run
);

    logic      step;
    tok_pair_t pair;
    tok_rec_t  head;

    assign step = s_valid && s_ready;

    sxl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (step),
        .in_byte (s_in_byte),
        .is_end  (s_is_end),
        .pair    (pair)
    );

    sxl_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (step),
        .pair    (pair),
        .room    (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .head    (head)
    );

    assign m_token_kind   = head.kind;
    assign m_start_line   = head.line;
    assign m_start_column = head.column;
    assign m_text_offset  = head.offset;
    assign m_text_length  = head.length;
    assign m_bad_byte     = head.bad;
    assign m_last_of_run  = head.last;

    `SXL_ASSERT_NOW(a_eof_last, m_valid && m_token_kind == K_EOF, m_last_of_run)
    `SXL_ASSERT_NOW(a_bad_only_badchar, m_valid && m_token_kind != K_BADCHR, m_bad_byte == 8'd0)
    `SXL_ASSERT_NEXT(a_end_emits, s_valid && s_ready && s_is_end, m_valid)

endmodule

`default_nettype wire
